// ===== hw/rtl/bfrt_pkg.sv =====
package bfrt_pkg;

  localparam logic [7:0] DEST_POSITION     = 8'd2;
  localparam logic [7:0] POLL_FRAME_LENGTH = 8'd1;
  localparam logic [7:0] OWN_ADDRESS_RESET = 8'd11;

  localparam logic ACTION_BYTE = 1'b0;
  localparam logic ACTION_TAG  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic       frame_end;
    logic       rx_error;
    logic [7:0] source_tag;
  } in_item_t;

  typedef struct packed {
    logic       wrote;
    logic [5:0] write_index;
    logic [7:0] write_value;
    logic       write_end_mark;
    logic [7:0] poll_address;
    logic       response_seen;
    logic       overflow;
  } out_item_t;

endpackage

// ===== hw/rtl/bfrt_ram.sv =====
module bfrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/bus_frame_receive_tracker.sv =====
// Bus frame receive tracker.
//
// in_*  : one item per received-byte event or tag request (in_item_t).
// out_* : exactly one result item per input item, in order (out_item_t).
// cfg_* : write of own_address; always ready, write only while idle.
//
// Items pass the middle stage, then the output register. Throughput: one
// item per cycle while out_ready is high. Fill index and frame counters
// update at accept; bytes and end bits share one RAM word per slot, read at
// accept and checked in stage 1 (sticky end bit, tag check), then written.
//
// Reset (rst_n low, synchronous): fill index, frame counters and poll
// address clear, own_address returns to 11, pipeline empties. The RAM is
// not cleared: until the fill index first wraps, slots at or above it
// count as never written, so every end bit starts at zero.
//
// Stall: while out_ready is low the output register holds its item, the
// middle stage may still fill, and then in_ready drops until space frees up.
module bus_frame_receive_tracker #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bfrt_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output bfrt_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  import bfrt_pkg::*;

  localparam int IDX_W = $clog2(BUFFER_DEPTH);

  // architectural state
  logic [7:0]              own_addr_r;
  logic [IDX_W-1:0]        fill_r, fill_nxt;
  logic                    wrapped_r, wrapped_nxt;   // fill index has wrapped once
  logic [7:0]              frame_len_r, frame_len_nxt;
  logic [7:0]              last_byte_r, last_byte_nxt;
  logic [7:0]              byte_pos_r, byte_pos_nxt;
  logic [7:0]              frame_dest_r, frame_dest_nxt;
  logic [7:0]              poll_r, poll_nxt;

  // middle stage
  logic             s1_valid_r;
  logic             s1_wrote_r, s1_wrote_nxt;   // data or end-marker write
  logic             s1_tag_r, s1_tag_nxt;       // tag candidate, needs store check
  logic             s1_known_r, s1_known_nxt;   // slot read has been written
  logic [IDX_W-1:0] s1_idx_r, s1_idx_nxt;
  logic [7:0]       s1_val_r, s1_val_nxt;
  logic             s1_wend_r, s1_wend_nxt;
  logic [7:0]       s1_poll_r;
  logic             s1_resp_r, s1_resp_nxt;
  logic             s1_ovf_r, s1_ovf_nxt;
  logic             s1_fwd_r;
  logic [8:0]       s1_fwd_data_r;

  // output register
  logic      out_valid_r;
  out_item_t out_r, out_nxt;

  logic             accept;
  logic             s1_adv;
  logic             fill_last;
  logic [IDX_W-1:0] tag_slot;
  logic [IDX_W-1:0] rd_addr;
  logic [8:0]       ram_rdata;
  logic [8:0]       cur_word;
  logic             rd_end;
  logic             wend;
  logic             tag_do;
  logic             ram_we;
  logic [8:0]       ram_wdata;
  logic             fwd_hit;

  assign s1_adv    = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign fill_last = (fill_r == IDX_W'(BUFFER_DEPTH - 1));
  assign tag_slot  = fill_r - IDX_W'(1);
  // a tag looks at the slot below the fill index, everything else at the fill slot
  assign rd_addr   = (in_item.action == ACTION_TAG) ? tag_slot : fill_r;

  // ---------------- stage 0: control state update at accept ----------------
  always_comb begin
    fill_nxt       = fill_r;
    wrapped_nxt    = wrapped_r;
    frame_len_nxt  = frame_len_r;
    last_byte_nxt  = last_byte_r;
    byte_pos_nxt   = byte_pos_r;
    frame_dest_nxt = frame_dest_r;
    poll_nxt       = poll_r;
    s1_wrote_nxt   = 1'b0;
    s1_tag_nxt     = 1'b0;
    s1_known_nxt   = wrapped_r;   // fill slot was written only on an earlier lap
    s1_idx_nxt     = fill_r;
    s1_val_nxt     = 8'd0;
    s1_wend_nxt    = 1'b0;
    s1_resp_nxt    = 1'b0;
    s1_ovf_nxt     = 1'b0;
    if (in_item.action == ACTION_BYTE) begin
      if (in_item.frame_end) begin
        s1_wrote_nxt   = 1'b1;
        s1_wend_nxt    = 1'b1;
        poll_nxt       = (frame_len_r == POLL_FRAME_LENGTH) ? last_byte_r : 8'd0;
        s1_resp_nxt    = (frame_len_r > POLL_FRAME_LENGTH) && (frame_dest_r == own_addr_r);
        frame_len_nxt  = 8'd0;
        byte_pos_nxt   = 8'd0;
        frame_dest_nxt = 8'd0;
      end else if (!in_item.rx_error) begin
        s1_wrote_nxt  = 1'b1;
        s1_val_nxt    = in_item.rx_byte;
        last_byte_nxt = in_item.rx_byte;
        frame_len_nxt = frame_len_r + 8'd1;
        byte_pos_nxt  = byte_pos_r + 8'd1;
        if (byte_pos_nxt == DEST_POSITION) begin
          frame_dest_nxt = in_item.rx_byte;
        end
      end
      if (s1_wrote_nxt) begin
        if (fill_last) begin
          fill_nxt    = '0;
          wrapped_nxt = 1'b1;
          s1_ovf_nxt  = 1'b1;
        end else begin
          fill_nxt = fill_r + IDX_W'(1);
        end
      end
    end else begin
      // tag: only the slot just below a nonzero fill index, if it is an end marker still holding zero
      s1_idx_nxt   = tag_slot;
      s1_val_nxt   = in_item.source_tag;
      s1_wend_nxt  = 1'b1;
      s1_tag_nxt   = (fill_r != '0);
      s1_known_nxt = (fill_r != '0);
    end
  end

  // ---------------- stage 1: store check and write back ----------------
  // The previous item writes the RAM at the same edge this item's read is
  // issued, so that write is forwarded.
  assign cur_word  = s1_fwd_r ? s1_fwd_data_r : ram_rdata;
  assign rd_end    = s1_known_r && cur_word[8];
  assign tag_do    = s1_tag_r && rd_end && (cur_word[7:0] == 8'd0);
  assign wend      = s1_wend_r || rd_end;   // end bits are sticky
  assign ram_wdata = {wend, s1_val_r};
  assign ram_we    = s1_valid_r && s1_adv && (s1_wrote_r || tag_do);
  assign fwd_hit   = ram_we && (s1_idx_r == rd_addr);

  always_comb begin
    out_nxt                = '0;
    out_nxt.poll_address   = s1_poll_r;
    out_nxt.response_seen  = s1_resp_r;
    out_nxt.overflow       = s1_ovf_r;
    if (s1_wrote_r || tag_do) begin
      out_nxt.wrote          = 1'b1;
      out_nxt.write_index    = 6'(s1_idx_r);
      out_nxt.write_value    = s1_val_r;
      out_nxt.write_end_mark = wend;
    end
  end

  bfrt_ram #(
    .WIDTH (9),
    .DEPTH (BUFFER_DEPTH)
  ) u_byte_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_idx_r),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r   <= OWN_ADDRESS_RESET;
      fill_r       <= '0;
      wrapped_r    <= 1'b0;
      frame_len_r  <= 8'd0;
      last_byte_r  <= 8'd0;
      byte_pos_r   <= 8'd0;
      frame_dest_r <= 8'd0;
      poll_r       <= 8'd0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        own_addr_r <= cfg_data;
      end
      if (accept) begin
        fill_r       <= fill_nxt;
        wrapped_r    <= wrapped_nxt;
        frame_len_r  <= frame_len_nxt;
        last_byte_r  <= last_byte_nxt;
        byte_pos_r   <= byte_pos_nxt;
        frame_dest_r <= frame_dest_nxt;
        poll_r       <= poll_nxt;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_wrote_r    <= s1_wrote_nxt;
      s1_tag_r      <= s1_tag_nxt;
      s1_known_r    <= s1_known_nxt;
      s1_idx_r      <= s1_idx_nxt;
      s1_val_r      <= s1_val_nxt;
      s1_wend_r     <= s1_wend_nxt;
      s1_poll_r     <= poll_nxt;
      s1_resp_r     <= s1_resp_nxt;
      s1_ovf_r      <= s1_ovf_nxt;
      s1_fwd_r      <= fwd_hit;
      s1_fwd_data_r <= ram_wdata;
    end
    if (s1_valid_r && s1_adv) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== hw/rtl/bfrt_checker.sv =====
module bfrt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input bfrt_pkg::out_item_t out_item
);

  import bfrt_pkg::*;

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // no write, no write fields
  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.wrote |->
      out_item.write_index == 6'd0 && out_item.write_value == 8'd0 &&
      !out_item.write_end_mark)
    else $error("write fields set without a write");

  // a response only comes with a frame-end marker write
  a_resp_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.response_seen |->
      out_item.wrote && out_item.write_end_mark && out_item.write_value == 8'd0)
    else $error("response without end marker");

  // overflow only when a slot was filled
  a_ovf_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.overflow |-> out_item.wrote)
    else $error("overflow without a write");

endmodule

bind bus_frame_receive_tracker bfrt_checker u_bfrt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
